### src/dlc_pkg.sv
// dlc_pkg: shared types, fixed-point constants and the rounded product
// for the decibel/linear converter. No dependencies.
package dlc_pkg;

  // fraction bits of the internal fixed-point format
  localparam int FRAC_BITS = 30;

  typedef logic signed [31:0] fx_t;   // Q2.30 operand
  typedef logic signed [35:0] fxw_t;  // product before narrowing

  // series constants, rounded to FRAC_BITS fraction bits
  localparam fx_t C_ONE     = fx_t'(32'sd1073741824);
  localparam fx_t C_HALF    = fx_t'(32'sd536870912);
  localparam fx_t C_QUARTER = fx_t'(32'sd268435456);
  localparam fx_t C_THIRD   = fx_t'(32'sd357913583);
  localparam fx_t C_LOG2E   = fx_t'(32'sd1549082004);
  localparam fx_t C_EXP1    = fx_t'(32'sd744260924);
  localparam fx_t C_EXP2    = fx_t'(32'sd257941777);
  localparam fx_t C_EXP3    = fx_t'(32'sd59596966);
  // 20 * log10(2) and its inverse, log2(10)/20
  localparam logic [32:0] C_DB    = 33'd6464570026;
  localparam logic [27:0] C_L2DB  = 28'd178344651;

  localparam logic [31:0] DB_FLOOR = 32'hFF700000;
  localparam logic [31:0] FP_INF   = 32'h7F800000;
  localparam logic [7:0]  EXP_BIAS = 8'd127;
  localparam logic        MODE_LIN2DB = 1'b0;
  localparam logic        MODE_DB2LIN = 1'b1;

  // classified input transaction
  typedef struct packed {
    logic        mode;
    logic        special;
    logic [31:0] operand;
  } dlc_item_t;

  // fixed-point product, rounded half away from zero
  function automatic fxw_t fmul(input fx_t a, input fx_t b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    logic [34:0] r;
    ua = a[31] ? 32'(-a) : 32'(a);
    ub = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ua) * 64'(ub);
    r  = 35'((p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    fmul = (a[31] ^ b[31]) ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

endpackage

### src/dlc_if.sv
// dlc_in_if / dlc_out_if: valid/ready channels of the converter
// depends on nothing
interface dlc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] operand;
  modport source(output valid, output mode, output operand, input ready);
  modport sink(input valid, input mode, input operand, output ready);
endinterface

interface dlc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        saturated;
  modport source(output valid, output result, output saturated, input ready);
  modport sink(input valid, input result, input saturated, output ready);
endinterface

### src/dlc_front.sv
// dlc_front: input register that accepts transactions and classifies them
// depends on dlc_pkg, dlc_in_if
module dlc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  dlc_in_if.sink             in_i,
  output logic               item_valid_o,
  output dlc_pkg::dlc_item_t item_o,
  input  logic               item_ready_i
);
  import dlc_pkg::*;

  logic      valid_q;
  dlc_item_t item_q, item_d;
  logic      is_nan;
  logic      take;

  // zero, denormal and negative non-nan inputs map to the dB floor
  always_comb begin
    is_nan = (in_i.operand[30:23] == 8'hFF) && (in_i.operand[22:0] != 23'd0);
    item_d.mode    = in_i.mode;
    item_d.operand = in_i.operand;
    item_d.special = (in_i.mode == MODE_LIN2DB) &&
                     ((in_i.operand[30:23] == 8'd0) || (in_i.operand[31] && !is_nan));
  end

  assign in_i.ready   = !valid_q || item_ready_i;
  assign take         = in_i.valid && in_i.ready;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end
endmodule

### src/dlc_fifo.sv
// dlc_fifo: two-entry queue between the front and the back end
// depends on dlc_pkg
module dlc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  dlc_pkg::dlc_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output dlc_pkg::dlc_item_t pop_item_o,
  input  logic               pop_ready_i
);
  import dlc_pkg::*;

  dlc_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == 2'd0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count not updated on push");
endmodule

### src/dlc_back.sv
// dlc_back: eight-stage conversion pipeline, both directions side by side
// depends on dlc_pkg, dlc_out_if
module dlc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  dlc_pkg::dlc_item_t item_i,
  output logic               item_ready_o,
  dlc_out_if.source          out_o
);
  import dlc_pkg::*;

  logic [7:0] v_q;
  logic       en;
  logic [7:0] mode_q, spec_q;

  assign en           = !v_q[7] || out_o.ready;
  assign item_ready_o = en;

  // valid bits and per-stage tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 8'd0;
    end else if (en) begin
      v_q <= {v_q[6:0], item_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q <= {mode_q[6:0], item_i.mode};
      spec_q <= {spec_q[6:0], item_i.special};
    end
  end

  // stage 1: mantissa square / level times log2(10)/20
  logic [7:0]  s1_ef_q;
  fx_t         s1_m_q, s1_m2_q, m_d;
  logic        s1_neg_q;
  logic [43:0] s1_e2_q, e2_d;
  logic [31:0] dmag;
  logic [59:0] dprod;
  always_comb begin
    m_d   = fx_t'({2'b00, item_i.operand[22:0], 7'b0});
    dmag  = item_i.operand[31] ? 32'(-item_i.operand) : item_i.operand;
    dprod = 60'(dmag) * 60'(C_L2DB);
    e2_d  = 44'((dprod + 60'd32768) >> 16);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ef_q  <= item_i.operand[30:23];
      s1_m_q   <= m_d;
      s1_m2_q  <= fx_t'(fmul(m_d, m_d));
      s1_neg_q <= item_i.operand[31];
      s1_e2_q  <= e2_d;
    end
  end

  // stage 2: cube and half square / split exponent and fraction, clamp
  logic [7:0]  s2_ef_q, s2_ec_q, ec_d;
  fx_t         s2_m_q, s2_m3_q, s2_t2_q, s2_fr_q, fr_d;
  logic        s2_sat_q, sat_d;
  logic signed [15:0] e16;
  always_comb begin
    fr_d = s1_neg_q ? -fx_t'({2'b00, s1_e2_q[29:0]}) : fx_t'({2'b00, s1_e2_q[29:0]});
    e16  = s1_neg_q ? 16'sd127 - $signed({2'b00, s1_e2_q[43:30]})
                    : 16'sd127 + $signed({2'b00, s1_e2_q[43:30]});
    sat_d = 1'b0;
    ec_d  = e16[7:0];
    if (e16 < 16'sd0) begin
      ec_d  = 8'd0;
      sat_d = 1'b1;
    end else if (e16 > 16'sd255) begin
      ec_d  = 8'd255;
      sat_d = 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ef_q  <= s1_ef_q;
      s2_m_q   <= s1_m_q;
      s2_m3_q  <= fx_t'(fmul(s1_m2_q, s1_m_q));
      s2_t2_q  <= fx_t'(fmul(s1_m2_q, C_HALF));
      s2_fr_q  <= fr_d;
      s2_ec_q  <= ec_d;
      s2_sat_q <= sat_d;
    end
  end

  // stage 3: fourth power and third term / first horner step
  logic [7:0] s3_ef_q, s3_ec_q;
  fx_t        s3_m_q, s3_m4_q, s3_t2_q, s3_t3_q, s3_fr_q, s3_a1_q;
  logic       s3_sat_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ef_q  <= s2_ef_q;
      s3_m_q   <= s2_m_q;
      s3_m4_q  <= fx_t'(fmul(s2_m3_q, s2_m_q));
      s3_t2_q  <= s2_t2_q;
      s3_t3_q  <= fx_t'(fmul(s2_m3_q, C_THIRD));
      s3_fr_q  <= s2_fr_q;
      s3_a1_q  <= fx_t'(fxw_t'(C_EXP2) + fmul(s2_fr_q, C_EXP3));
      s3_ec_q  <= s2_ec_q;
      s3_sat_q <= s2_sat_q;
    end
  end

  // stage 4: series sum / second horner step
  logic [7:0] s4_ef_q, s4_ec_q;
  fx_t        s4_s_q, s4_fr_q, s4_a2_q;
  logic       s4_sat_q;
  fxw_t       sum_d;
  always_comb begin
    sum_d = fxw_t'(s3_m_q) - fxw_t'(s3_t2_q) + fxw_t'(s3_t3_q)
            - fmul(s3_m4_q, C_QUARTER);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ef_q  <= s3_ef_q;
      s4_s_q   <= fx_t'(sum_d);
      s4_fr_q  <= s3_fr_q;
      s4_a2_q  <= fx_t'(fxw_t'(C_EXP1) + fmul(s3_fr_q, s3_a1_q));
      s4_ec_q  <= s3_ec_q;
      s4_sat_q <= s3_sat_q;
    end
  end

  // stage 5: log2 with exponent / last horner step
  logic signed [39:0] s5_l2_q;
  logic signed [8:0]  ex;
  fx_t                s5_f2_q;
  logic [7:0]         s5_ec_q;
  logic               s5_sat_q;
  assign ex = $signed({1'b0, s4_ef_q}) - $signed({1'b0, EXP_BIAS});
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_l2_q  <= (40'(ex) <<< FRAC_BITS) + 40'(fmul(s4_s_q, C_LOG2E));
      s5_f2_q  <= fx_t'(fxw_t'(C_ONE) + fmul(s4_fr_q, s4_a2_q));
      s5_ec_q  <= s4_ec_q;
      s5_sat_q <= s4_sat_q;
    end
  end

  // stage 6: partial products for dB scale / normalize the mantissa
  logic [38:0]       l2mag;
  logic [54:0]       s6_plo_q;
  logic [55:0]       s6_phi_q;
  logic              s6_neg_q;
  logic [31:0]       uf;
  logic signed [9:0] en_e;
  logic [30:0]       s6_uf_q;
  logic signed [9:0] s6_e_q;
  logic              s6_zero_q, s6_inf_q, s6_sat_q;
  always_comb begin
    l2mag = s5_l2_q[39] ? 39'(-s5_l2_q) : 39'(s5_l2_q);
    uf    = 32'(s5_f2_q);
    en_e  = $signed({2'b00, s5_ec_q});
    for (int i = 0; i < 3; i++) begin
      if (uf < (32'd1 << FRAC_BITS)) begin
        uf   = uf << 1;
        en_e = en_e - 10'sd1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_neg_q  <= s5_l2_q[39];
      s6_plo_q  <= 55'(l2mag) * 55'(C_DB[15:0]);
      s6_phi_q  <= 56'(l2mag) * 56'(C_DB[32:16]);
      s6_uf_q   <= uf[30:0];
      s6_e_q    <= en_e;
      s6_zero_q <= (s5_ec_q == 8'd0) || (s5_f2_q <= 0);
      s6_inf_q  <= (s5_ec_q == 8'd255);
      s6_sat_q  <= s5_sat_q;
    end
  end

  // stage 7: sum and round to Q30 / round mantissa to nearest even
  logic [71:0]       prod;
  logic [42:0]       s7_db_q;
  logic              s7_neg_q;
  logic [24:0]       q;
  logic [6:0]        rem;
  logic signed [9:0] e7;
  logic [22:0]       s7_man_q;
  logic signed [9:0] s7_e_q;
  logic              s7_zero_q, s7_inf_q, s7_sat_q;
  always_comb begin
    prod = {s6_phi_q, 16'b0} + 72'(s6_plo_q);
    q    = {1'b0, s6_uf_q[30:7]};
    rem  = s6_uf_q[6:0];
    e7   = s6_e_q;
    if (rem > 7'd64 || (rem == 7'd64 && q[0])) q = q + 25'd1;
    if (q[24]) begin
      q  = q >> 1;
      e7 = e7 + 10'sd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_db_q   <= 43'((prod + (72'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      s7_neg_q  <= s6_neg_q;
      s7_man_q  <= q[22:0];
      s7_e_q    <= e7;
      s7_zero_q <= s6_zero_q;
      s7_inf_q  <= s6_inf_q;
      s7_sat_q  <= s6_sat_q;
    end
  end

  // stage 8: output register
  logic [28:0] dbq;
  logic [31:0] res_d, res_q;
  logic        sat_o_d, sat_q;
  always_comb begin
    dbq     = 29'((s7_db_q + 43'd8192) >> 14);
    sat_o_d = 1'b0;
    if (mode_q[6] == MODE_LIN2DB) begin
      res_d = spec_q[6] ? DB_FLOOR : (s7_neg_q ? 32'(-{3'b0, dbq}) : {3'b0, dbq});
    end else begin
      sat_o_d = s7_sat_q;
      if (s7_zero_q || s7_e_q <= 10'sd0) begin
        res_d = 32'd0;
      end else if (s7_inf_q || s7_e_q >= 10'sd255) begin
        res_d = FP_INF;
      end else begin
        res_d = {1'b0, s7_e_q[7:0], s7_man_q};
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_o_d;
    end
  end

  assign out_o.valid     = v_q[7];
  assign out_o.result    = res_q;
  assign out_o.saturated = sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[7] && mode_q[7] == MODE_LIN2DB) |-> !sat_q)
    else $error("saturation flagged on a dB result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[7] && sat_q) |-> (res_q == 32'd0 || res_q == FP_INF))
    else $error("saturated result is neither zero nor infinity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (v_q[7] && !out_o.ready) |=> (v_q[7] && $stable(res_q) && $stable(v_q)))
    else $error("pipeline moved while output stalled");
endmodule

### src/decibel_linear_converter.sv
// decibel_linear_converter: float32 amplitude <-> Q16.16 dB level
// the accept edge loads the input register, then the queue is written, then the
// item passes the eight pipeline stages; throughput: one transaction per cycle
// when out_o.ready is high, set by the fully pipelined multiplier stages;
// asynchronous active-low reset empties all stages
module decibel_linear_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlc_in_if.sink    in_i,
  dlc_out_if.source out_o
);
  import dlc_pkg::*;

  logic      fr_valid, fr_ready;
  dlc_item_t fr_item;
  logic      bk_valid, bk_ready;
  dlc_item_t bk_item;

  // accept and classify
  dlc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_valid_o(fr_valid),
    .item_o      (fr_item),
    .item_ready_i(fr_ready)
  );

  // decoupling queue
  dlc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_item_i (fr_item),
    .push_ready_o(fr_ready),
    .pop_valid_o (bk_valid),
    .pop_item_o  (bk_item),
    .pop_ready_i (bk_ready)
  );

  // conversion pipeline
  dlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(bk_valid),
    .item_i      (bk_item),
    .item_ready_o(bk_ready),
    .out_o       (out_o)
  );
endmodule
